FILE: hw/rtl/hla_pkg.sv
// ----------------------------------------------------------------------------
// hla_pkg: shared constants, types and helpers
// Sizes, character codes, token modes and result types of the hex label
// assembler.
// ----------------------------------------------------------------------------
package hla_pkg;

  localparam int NAME_LEN   = 60;
  localparam int MAX_LABELS = 256;

  localparam int NL_W = $clog2(NAME_LEN + 1);
  localparam int NI_W = $clog2(NAME_LEN);
  localparam int LC_W = $clog2(MAX_LABELS + 1);
  localparam int LI_W = $clog2(MAX_LABELS);
  localparam int NA_W = $clog2(MAX_LABELS * NAME_LEN);

  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_AT    = 8'd64;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;

  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_COMMENT    = 3'd1;
  localparam logic [2:0] MODE_LABEL_NAME = 3'd2;
  localparam logic [2:0] MODE_LABEL_SKIP = 3'd3;
  localparam logic [2:0] MODE_PTR_SKIP   = 3'd4;
  localparam logic [2:0] MODE_PTR_NAME   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic push;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

  // Returns {valid, value} for a hexadecimal digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'd48 && c <= 8'd57) v = {1'b1, 4'(c - 8'd48)};
    else if (c >= 8'd97 && c <= 8'd102) v = {1'b1, 4'(c - 8'd87)};
    else if (c >= 8'd65 && c <= 8'd70) v = {1'b1, 4'(c - 8'd55)};
    return v;
  endfunction

endpackage

FILE: hw/rtl/hla_if.sv
// ----------------------------------------------------------------------------
// hla_if: channel interfaces
// Source character channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hla_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface hla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic [1:0] status;
  modport source (output valid, output out_byte, output last_of_run, output status,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input status,
                output ready);
endinterface

FILE: hw/rtl/hla_name_buf.sv
// ----------------------------------------------------------------------------
// hla_name_buf: name buffer
// Holds the name being read; entries at or beyond the length read as zero.
// ----------------------------------------------------------------------------
module hla_name_buf
  import hla_pkg::*;
(
  input  logic            clk,
  input  logic            we,
  input  logic [NI_W-1:0] waddr,
  input  logic [7:0]      wdata,
  input  logic [NI_W-1:0] raddr,
  input  logic [NL_W-1:0] len,
  output logic [7:0]      rdata
);

  logic [7:0] mem [NAME_LEN];
  logic [7:0] data_r;
  logic       live_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    data_r <= mem[raddr];
    live_r <= NL_W'(raddr) < len;
  end

  assign rdata = live_r ? data_r : 8'd0;

endmodule

FILE: hw/rtl/hla_label_tab.sv
// ----------------------------------------------------------------------------
// hla_label_tab: label table
// Stores padded label names and their target addresses.
// ----------------------------------------------------------------------------
module hla_label_tab
  import hla_pkg::*;
(
  input  logic            clk,
  input  logic            n_we,
  input  logic [NA_W-1:0] n_waddr,
  input  logic [7:0]      n_wdata,
  input  logic [NA_W-1:0] n_raddr,
  output logic [7:0]      n_rdata,
  input  logic            t_we,
  input  logic [LI_W-1:0] t_waddr,
  input  logic [31:0]     t_wdata,
  input  logic [LI_W-1:0] t_raddr,
  output logic [31:0]     t_rdata
);

  logic [7:0]  names [MAX_LABELS * NAME_LEN];
  logic [31:0] targets [MAX_LABELS];

  always_ff @(posedge clk) begin
    if (n_we) begin
      names[n_waddr] <= n_wdata;
    end
    n_rdata <= names[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      targets[t_waddr] <= t_wdata;
    end
    t_rdata <= targets[t_raddr];
  end

endmodule

FILE: hw/rtl/hla_out_fifo.sv
// ----------------------------------------------------------------------------
// hla_out_fifo: result queue
// Four-entry queue that takes one or two results at once.
// ----------------------------------------------------------------------------
module hla_out_fifo
  import hla_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  output logic   room,
  output logic [2:0] count,
  hla_out_if.source out_ch
);

  res_t       q [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      rp_nxt  = rp_r + 2'd1;
      cnt_nxt = cnt_nxt - 3'd1;
    end
    if (push.push) begin
      wp_nxt  = wp_r + (push.two ? 2'd2 : 2'd1);
      cnt_nxt = cnt_nxt + (push.two ? 3'd2 : 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      q[wp_r] <= push.r0;
      if (push.two) begin
        q[wp_r + 2'd1] <= push.r1;
      end
    end
  end

  assign room               = cnt_r <= 3'd2;
  assign count              = cnt_r;
  assign out_ch.valid       = cnt_r != 3'd0;
  assign out_ch.out_byte    = q[rp_r].out_byte;
  assign out_ch.last_of_run = q[rp_r].last_of_run;
  assign out_ch.status      = q[rp_r].status;

endmodule

FILE: hw/rtl/hex_label_assembler_top.sv
// ----------------------------------------------------------------------------
// hex_label_assembler_top: two-pass hex assembler with labels
// Parses characters, records labels in pass one and resolves pointers in
// pass two with a byte-serial compare over the label table.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     in         kind, char_code
// out_ch    out        out_byte, last_of_run, status
//
// An ordinary character is handled in the idle state without leaving it.
// Ending a label name copies it into the table, reading each byte from the name buffer and then writing it.
// Ending a pointer name compares it byte by byte against the labels, with a
// read state and a compare state per byte, moving on at the first mismatch.
// Input is taken only when idle and the result queue has room for two items.
// Reset (synchronous, active low) clears control state and the label count.
// ----------------------------------------------------------------------------
module hex_label_assembler_top
  import hla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hla_in_if.sink    in_ch,
  hla_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CPY_RD = 3'd1;
  localparam logic [2:0] S_CPY_WR = 3'd2;
  localparam logic [2:0] S_LK_RD  = 3'd3;
  localparam logic [2:0] S_LK_CMP = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      mode_r, mode_nxt;
  logic            pass2_r, pass2_nxt;
  logic            pend_r, pend_nxt;
  logic [3:0]      hi_r, hi_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [LC_W-1:0] lcount_r, lcount_nxt;
  logic [NL_W-1:0] nlen_r, nlen_nxt;
  logic [NI_W-1:0] j_r, j_nxt;
  logic [LC_W-1:0] i_r, i_nxt;
  logic [NA_W-1:0] rbase_r, rbase_nxt, wbase_r, wbase_nxt;

  logic            acc, room;
  logic [2:0]      qcount;
  logic [7:0]      c;
  logic [4:0]      hv;
  logic            name_end;
  push_t           push;
  logic            nb_we, t_we, n_we;
  logic [7:0]      nb_rdata, n_rdata;
  logic [31:0]     t_rdata;
  logic [15:0]     pval;

  assign in_ch.ready = (state_r == S_IDLE) && room;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_code;
  assign hv          = hex_value(c);
  assign name_end    = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF);
  assign pval        = t_rdata[15:0] - addr_r[15:0] + 16'd4;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pass2_nxt  = pass2_r;
    pend_nxt   = pend_r;
    hi_nxt     = hi_r;
    addr_nxt   = addr_r;
    lcount_nxt = lcount_r;
    nlen_nxt   = nlen_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    rbase_nxt  = rbase_r;
    wbase_nxt  = wbase_r;
    nb_we      = 1'b0;
    t_we       = 1'b0;
    n_we       = 1'b0;
    push       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_ch.kind) begin
          pass2_nxt = 1'b1;
          mode_nxt  = MODE_NORMAL;
          pend_nxt  = 1'b0;
          hi_nxt    = 4'd0;
          addr_nxt  = 32'd0;
          nlen_nxt  = '0;
        end else if (acc) begin
          unique case (mode_r)
            MODE_COMMENT: begin
              if (c == CH_LF || c == CH_CR) mode_nxt = MODE_NORMAL;
            end
            MODE_LABEL_SKIP, MODE_PTR_SKIP: begin
              if (name_end) mode_nxt = MODE_NORMAL;
            end
            MODE_LABEL_NAME, MODE_PTR_NAME: begin
              if (!name_end) begin
                if (nlen_r < NL_W'(NAME_LEN)) begin
                  nb_we    = 1'b1;
                  nlen_nxt = nlen_r + NL_W'(1);
                end
              end else begin
                mode_nxt = MODE_NORMAL;
                j_nxt    = '0;
                if (mode_r == MODE_LABEL_NAME) begin
                  if (lcount_r >= LC_W'(MAX_LABELS)) begin
                    push.push = 1'b1;
                    push.r0   = '{8'd0, 1'b1, ST_FULL};
                  end else begin
                    t_we      = 1'b1;
                    state_nxt = S_CPY_RD;
                  end
                end else if (lcount_r == '0) begin
                  push.push = 1'b1;
                  push.two  = 1'b1;
                  push.r0   = '{8'd0, 1'b0, ST_UNDEF};
                  push.r1   = '{8'd0, 1'b1, ST_UNDEF};
                end else begin
                  i_nxt     = '0;
                  rbase_nxt = '0;
                  state_nxt = S_LK_RD;
                end
              end
            end
            default: begin
              if (c == CH_COLON) begin
                if (pass2_r) begin
                  mode_nxt = MODE_LABEL_SKIP;
                end else begin
                  nlen_nxt = '0;
                  mode_nxt = MODE_LABEL_NAME;
                end
              end else if (c == CH_AT) begin
                addr_nxt = addr_r + 32'd2;
                if (pass2_r) begin
                  nlen_nxt = '0;
                  mode_nxt = MODE_PTR_NAME;
                end else begin
                  mode_nxt = MODE_PTR_SKIP;
                end
              end else if (c == CH_HASH || c == CH_SEMI) begin
                mode_nxt = MODE_COMMENT;
              end else if (hv[4]) begin
                if (!pend_r) begin
                  hi_nxt   = hv[3:0];
                  pend_nxt = 1'b1;
                end else begin
                  pend_nxt = 1'b0;
                  hi_nxt   = 4'd0;
                  addr_nxt = addr_r + 32'd1;
                  if (pass2_r) begin
                    push.push = 1'b1;
                    push.r0   = '{{hi_r, hv[3:0]}, 1'b1, ST_OK};
                  end
                end
              end
            end
          endcase
        end
      end
      S_CPY_RD: state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        n_we = 1'b1;
        if (j_r == NI_W'(NAME_LEN - 1)) begin
          lcount_nxt = lcount_r + LC_W'(1);
          wbase_nxt  = wbase_r + NA_W'(NAME_LEN);
          state_nxt  = S_IDLE;
        end else begin
          j_nxt     = j_r + NI_W'(1);
          state_nxt = S_CPY_RD;
        end
      end
      S_LK_RD: state_nxt = S_LK_CMP;
      S_LK_CMP: begin
        if (n_rdata != nb_rdata) begin
          if (i_r + LC_W'(1) == lcount_r) begin
            push.push = 1'b1;
            push.two  = 1'b1;
            push.r0   = '{8'd0, 1'b0, ST_UNDEF};
            push.r1   = '{8'd0, 1'b1, ST_UNDEF};
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + LC_W'(1);
            rbase_nxt = rbase_r + NA_W'(NAME_LEN);
            j_nxt     = '0;
            state_nxt = S_LK_RD;
          end
        end else if (j_r == NI_W'(NAME_LEN - 1)) begin
          push.push = 1'b1;
          push.two  = 1'b1;
          push.r0   = '{pval[15:8], 1'b0, ST_OK};
          push.r1   = '{pval[7:0], 1'b1, ST_OK};
          state_nxt = S_IDLE;
        end else begin
          j_nxt     = j_r + NI_W'(1);
          state_nxt = S_LK_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= MODE_NORMAL;
      pass2_r  <= 1'b0;
      pend_r   <= 1'b0;
      hi_r     <= 4'd0;
      addr_r   <= 32'd0;
      lcount_r <= '0;
      nlen_r   <= '0;
      wbase_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      pass2_r  <= pass2_nxt;
      pend_r   <= pend_nxt;
      hi_r     <= hi_nxt;
      addr_r   <= addr_nxt;
      lcount_r <= lcount_nxt;
      nlen_r   <= nlen_nxt;
      wbase_r  <= wbase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    i_r     <= i_nxt;
    rbase_r <= rbase_nxt;
  end

  hla_name_buf u_name_buf (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nlen_r[NI_W-1:0]),
    .wdata (c),
    .raddr (j_r),
    .len   (nlen_r),
    .rdata (nb_rdata)
  );

  hla_label_tab u_label_tab (
    .clk     (clk),
    .n_we    (n_we),
    .n_waddr (wbase_r + NA_W'(j_r)),
    .n_wdata (nb_rdata),
    .n_raddr (rbase_r + NA_W'(j_r)),
    .n_rdata (n_rdata),
    .t_we    (t_we),
    .t_waddr (lcount_r[LI_W-1:0]),
    .t_wdata (addr_r),
    .t_raddr (i_r[LI_W-1:0]),
    .t_rdata (t_rdata)
  );

  hla_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .count  (qcount),
    .out_ch (out_ch)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE)
    else $error("Input taken while the sequencer is busy.");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    lcount_r <= LC_W'(MAX_LABELS))
    else $error("Label count beyond the table size.");

  a_queue_max: assert property (@(posedge clk) disable iff (!rst_n)
    qcount <= 3'd4)
    else $error("Result queue overflow.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push && state_r == S_IDLE) |-> $past(room) || room)
    else $error("Result pushed without room.");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the hex label assembler
// Feeds source text for both passes through the character channel, predicts
// every emitted byte and status in step with the accepted items, and checks
// each result against the oldest prediction under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;
  import hla_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hla_in_if  in_ch ();
  hla_out_if out_ch ();

  hex_label_assembler_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Predicted assembler state.
  logic        in_pass_two;
  logic [2:0]  scan_mode;
  logic        half_byte;
  logic [3:0]  top_nibble;
  logic [31:0] cur_addr;
  int          n_labels;
  logic [7:0]  lbl_name [MAX_LABELS][NAME_LEN];
  logic [31:0] lbl_addr [MAX_LABELS];
  logic [7:0]  name_buf [NAME_LEN];
  int          name_len;

  res_t        pending_bytes [$];
  int          n_errors = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_left = 0;
  string       known_names [$];

  function automatic void push_byte(logic [7:0] b, logic last, logic [1:0] st);
    res_t r;
    r.out_byte = b;
    r.last_of_run = last;
    r.status = st;
    pending_bytes.push_back(r);
  endfunction

  function automatic void wipe_name();
    for (int i = 0; i < NAME_LEN; i++) name_buf[i] = 8'd0;
    name_len = 0;
  endfunction

  function automatic void take_name_char(logic [7:0] c);
    if (name_len < NAME_LEN) begin
      name_buf[name_len] = c;
      name_len++;
    end
  endfunction

  function automatic logic ends_name(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF;
  endfunction

  function automatic void assemble_char(logic k, logic [7:0] c);
    int digit;
    int hit;
    logic same;
    logic [15:0] offs;
    digit = -1;
    hit = -1;
    if (k) begin
      in_pass_two = 1'b1;
      scan_mode = MODE_NORMAL;
      half_byte = 1'b0;
      top_nibble = 4'd0;
      cur_addr = 32'd0;
      wipe_name();
      return;
    end
    case (scan_mode)
      MODE_COMMENT: begin
        if (c == CH_LF || c == CH_CR) scan_mode = MODE_NORMAL;
        return;
      end
      MODE_LABEL_SKIP, MODE_PTR_SKIP: begin
        if (ends_name(c)) scan_mode = MODE_NORMAL;
        return;
      end
      MODE_LABEL_NAME: begin
        if (!ends_name(c)) begin
          take_name_char(c);
          return;
        end
        scan_mode = MODE_NORMAL;
        if (n_labels >= MAX_LABELS) begin
          push_byte(8'd0, 1'b1, ST_FULL);
          return;
        end
        for (int i = 0; i < NAME_LEN; i++) lbl_name[n_labels][i] = name_buf[i];
        lbl_addr[n_labels] = cur_addr;
        n_labels++;
        return;
      end
      MODE_PTR_NAME: begin
        if (!ends_name(c)) begin
          take_name_char(c);
          return;
        end
        scan_mode = MODE_NORMAL;
        for (int i = 0; i < n_labels && hit < 0; i++) begin
          same = 1'b1;
          for (int j = 0; j < NAME_LEN; j++)
            if (lbl_name[i][j] != name_buf[j]) same = 1'b0;
          if (same) hit = i;
        end
        if (hit >= 0) begin
          offs = 16'(lbl_addr[hit] - cur_addr + 32'd4);
          push_byte(offs[15:8], 1'b0, ST_OK);
          push_byte(offs[7:0], 1'b1, ST_OK);
        end else begin
          push_byte(8'd0, 1'b0, ST_UNDEF);
          push_byte(8'd0, 1'b1, ST_UNDEF);
        end
        return;
      end
      default: ;
    endcase
    if (c == CH_COLON) begin
      if (in_pass_two) scan_mode = MODE_LABEL_SKIP;
      else begin
        wipe_name();
        scan_mode = MODE_LABEL_NAME;
      end
      return;
    end
    if (c == CH_AT) begin
      cur_addr = cur_addr + 32'd2;
      if (in_pass_two) begin
        wipe_name();
        scan_mode = MODE_PTR_NAME;
      end else scan_mode = MODE_PTR_SKIP;
      return;
    end
    if (c == CH_HASH || c == CH_SEMI) begin
      scan_mode = MODE_COMMENT;
      return;
    end
    if (c >= "0" && c <= "9") digit = c - "0";
    else if (c >= "a" && c <= "f") digit = c - "a" + 10;
    else if (c >= "A" && c <= "F") digit = c - "A" + 10;
    if (digit < 0) return;
    if (!half_byte) begin
      top_nibble = 4'(digit);
      half_byte = 1'b1;
      return;
    end
    half_byte = 1'b0;
    cur_addr = cur_addr + 32'd1;
    if (in_pass_two) push_byte({top_nibble, 4'(digit)}, 1'b1, ST_OK);
    top_nibble = 4'd0;
  endfunction

  task automatic send_item(logic k, logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.char_code <= c;
    do @(posedge clk); while (!in_ch.ready);
    assemble_char(k, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result byte %h last %b status %0d", $time,
                 out_ch.out_byte, out_ch.last_of_run, out_ch.status);
        n_errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.out_byte || out_ch.last_of_run !== want.last_of_run
            || out_ch.status !== want.status) begin
          $display("%0t: expected byte %h last %b status %0d, got byte %h last %b status %0d",
                   $time, want.out_byte, want.last_of_run, want.status,
                   out_ch.out_byte, out_ch.last_of_run, out_ch.status);
          n_errors++;
        end
      end
    end
  end

  task automatic test_pass_one_labels();
    string long_name;
    long_name = "long";
    for (int i = 0; i < 66; i++) long_name = {long_name, "x"};
    send_text("1:start 2 @loop 34 #c@m:q\n:loop AB ;zz\r:loop cd\tgG");
    send_text({"0:", long_name, " 9f"});
    send_text(":n");
    send_item(1'b0, 8'd0);
    send_item(1'b0, CH_CR);
    send_text("m ff 5 ");
    known_names.push_back("start");
    known_names.push_back("loop");
    known_names.push_back(long_name);
  endtask

  task automatic test_table_full();
    string nm;
    for (int i = 0; i < MAX_LABELS + 2; i++) begin
      if ((i % 37) == 0) begin
        nm = $sformatf("z%0d", i);
        send_text({":", nm, (i % 2) ? "\t" : "\n"});
        if (i < MAX_LABELS) known_names.push_back(nm);
      end else begin
        send_text((i % 2) ? ":\t" : ": ");
      end
    end
    send_item(1'b1, 8'd0);
  endtask

  task automatic test_pass_two_directed();
    string near_long;
    near_long = "long";
    for (int i = 0; i < 56; i++) near_long = {near_long, "x"};
    send_text("12 @start @loop :start 3 4@nope ");
    send_text({"@", near_long, "QQ "});
    send_text("@n");
    send_item(1'b0, 8'd0);
    send_item(1'b0, CH_CR);
    send_text("m\n@z3 00FF 7a#@x\n");
    send_item(1'b1, 8'd0);
  endtask

  task automatic random_token(output int n_sent);
    int r;
    int n;
    string hexc;
    string tok;
    hexc = "0123456789abcdefABCDEF";
    r = $urandom_range(99);
    n_sent = 0;
    if (r < 40) begin
      send_item(1'b0, hexc[$urandom_range(21)]);
      send_item(1'b0, hexc[$urandom_range(21)]);
      n_sent = 2;
    end else if (r < 58) begin
      tok = {"@", known_names[$urandom_range(known_names.size() - 1)], " "};
      send_text(tok);
      n_sent = tok.len();
    end else if (r < 63) begin
      tok = $sformatf("@w%0d\t", $urandom_range(999));
      send_text(tok);
      n_sent = tok.len();
    end else if (r < 70) begin
      send_item(1'b0, ($urandom_range(1)) ? CH_HASH : CH_SEMI);
      n = $urandom_range(5);
      for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(255)));
      send_item(1'b0, ($urandom_range(1)) ? CH_LF : CH_CR);
      n_sent = n + 2;
    end else if (r < 75) begin
      tok = $sformatf(":s%0d ", $urandom_range(99));
      send_text(tok);
      n_sent = tok.len();
    end else if (r < 92) begin
      send_item(1'b0, 8'($urandom_range(255)));
      n_sent = 1;
    end else if (r < 94) begin
      send_item(1'b1, 8'($urandom_range(255)));
      n_sent = 1;
    end else begin
      send_item(1'b0, ($urandom_range(1)) ? CH_SP : CH_LF);
      n_sent = 1;
    end
  endtask

  task automatic test_random(int src_pct, int sink_pct, int n_items);
    int sent;
    int k;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      random_token(k);
      sent += k;
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 20; i++) send_text("5A");
    send_text("@start @w1 ");
    wait_drained();
    repeat (50) @(posedge clk);
    send_text("C3 @loop ");
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.char_code = 8'd0;
    out_ch.ready = 1'b0;
    in_pass_two = 1'b0;
    scan_mode = MODE_NORMAL;
    half_byte = 1'b0;
    top_nibble = 4'd0;
    cur_addr = 32'd0;
    n_labels = 0;
    wipe_name();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_pass_one_labels();
    test_table_full();
    test_pass_two_directed();
    test_random(10, 46, 50);
    test_random(46, 10, 50);
    test_random(0, 0, 50);
    test_backpressure();
    wait_drained();
    repeat (500) @(posedge clk);
    if (pending_bytes.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("** hex_label_assembler_top: PASSED **");
    end else begin
      $display("** hex_label_assembler_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("** hex_label_assembler_top: FAILED **");
    $finish;
  end

endmodule
